// ----- rtl/c8_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and tables for the CHIP-8 interpreter core.
// No dependencies; used by c8_datapath, c8_control and the top level.
package c8_pkg;

  localparam int RAM_BYTES     = 4096;
  localparam int RAM_AW        = $clog2(RAM_BYTES);
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int FRAME_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int FRAME_AW      = $clog2(FRAME_SIZE);
  localparam int STACK_DEPTH   = 16;
  localparam int FONT_BYTES    = 80;
  localparam int FONT_AW       = $clog2(FONT_BYTES);

  localparam logic [RAM_AW-1:0] PROG_START = RAM_AW'(12'h200);
  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_INC = 32'd2531011;
  localparam logic [3:0]  BCD_LAST = 4'd2;

  localparam logic [2:0] KIND_FULL_RESET = 3'd0;
  localparam logic [2:0] KIND_SOFT_RESET = 3'd1;
  localparam logic [2:0] KIND_ROM_BYTE   = 3'd2;
  localparam logic [2:0] KIND_KEY        = 3'd3;
  localparam logic [2:0] KIND_FRAME_RUN  = 3'd4;
  localparam logic [2:0] KIND_PIXEL_READ = 3'd5;

  localparam logic [1:0] CFG_IPF   = 2'd0;
  localparam logic [1:0] CFG_VSYNC = 2'd1;
  localparam logic [1:0] CFG_WRAP  = 2'd2;

  localparam logic [7:0] OP_CLS      = 8'hE0;
  localparam logic [7:0] OP_RET      = 8'hEE;
  localparam logic [7:0] OP_SKP      = 8'h9E;
  localparam logic [7:0] OP_SKNP     = 8'hA1;
  localparam logic [7:0] OP_GET_DT   = 8'h07;
  localparam logic [7:0] OP_WAIT_KEY = 8'h0A;
  localparam logic [7:0] OP_SET_DT   = 8'h15;
  localparam logic [7:0] OP_SET_ST   = 8'h18;
  localparam logic [7:0] OP_ADD_I    = 8'h1E;
  localparam logic [7:0] OP_FONT     = 8'h29;
  localparam logic [7:0] OP_BCD      = 8'h33;
  localparam logic [7:0] OP_STORE    = 8'h55;
  localparam logic [7:0] OP_LOAD     = 8'h65;

  localparam logic [3:0] GRP_SYS    = 4'h0;
  localparam logic [3:0] GRP_JMP_V0 = 4'hB;
  localparam logic [3:0] GRP_DRAW   = 4'hD;
  localparam logic [3:0] GRP_MISC   = 4'hF;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_SWEEP, ST_PIX_DATA, ST_RUN_START,
    ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_READ_X, ST_READ_Y, ST_EXEC,
    ST_CLS, ST_SPR_ROW, ST_SPR_LINE, ST_SPR_BIT, ST_SPR_XOR,
    ST_BCD, ST_STORE, ST_LOAD_ADDR, ST_LOAD_DATA,
    ST_POST, ST_TIMERS, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    RA_SWEEP, RA_PC, RA_PC1, RA_IDX, RA_ROM, RA_SPRITE
  } ram_asel_t;

  typedef enum logic [2:0] {
    RW_ZERO, RW_FONT, RW_ROM, RW_BCD, RW_VREG
  } ram_wsel_t;

  typedef enum logic [1:0] {
    FA_SWEEP, FA_PIXEL, FA_SPRITE
  } frame_asel_t;

  typedef enum logic [1:0] {
    VS_X, VS_Y, VS_ZERO, VS_LOOP
  } vsel_t;

  typedef struct packed {
    ram_asel_t   ram_asel;
    logic        ram_we;
    ram_wsel_t   ram_wsel;
    frame_asel_t frame_asel;
    logic        frame_we;
    logic        frame_toggle;
    vsel_t       vsel;
    logic        accept;
    logic        machine_clear;
    logic        key_write;
    logic        run_start;
    logic        pix_latch;
    logic        op_hi_latch;
    logic        op_lo_latch;
    logic        va_latch;
    logic        vb_latch;
    logic        pc_step;
    logic        exec;
    logic        draw_set;
    logic        vf_hit;
    logic        v_load;
    logic        sweep_clr;
    logic        sweep_inc;
    logic        loop_clr;
    logic        loop_inc;
    logic        spr_start;
    logic        row_inc;
    logic        line_latch;
    logic        bit_inc;
    logic        hit_update;
    logic        count_inc;
    logic        timers_dec;
    logic        out_load;
  } cmd_t;

  typedef struct packed {
    logic [15:0] op;
    logic        sweep_last_ram;
    logic        sweep_last_frame;
    logic        sweep_in_frame;
    logic        sweep_font;
    logic        loop_last;
    logic        bcd_last;
    logic        row_end;
    logic        bit_end;
    logic        pix_hit;
    logic        ipf_zero;
    logic        count_last;
    logic        stop_vsync;
    logic        out_busy;
  } stat_t;

endpackage

// ----- rtl/c8_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/c8_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: machine registers, program RAM, frame memory, ALU and output register.
// Depends on c8_pkg and c8_ram; driven by c8_control through cmd_t.
module c8_datapath (
  input  logic                clk,
  input  logic                rst,
  input  c8_pkg::cmd_t        cmd,
  output c8_pkg::stat_t       stat,
  input  logic [11:0]         rom_offset,
  input  logic [7:0]          data_byte,
  input  logic [3:0]          key_index,
  input  logic                key_pressed,
  input  logic [5:0]          pixel_x,
  input  logic [4:0]          pixel_y,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                draw_flag,
  output logic                sound_on,
  output logic                pixel_value,
  output logic [15:0]         instructions_done
);

  localparam int RAM_AW   = c8_pkg::RAM_AW;
  localparam int FRAME_AW = c8_pkg::FRAME_AW;

  logic [15:0] ipf;
  logic        vsync;
  logic        wrap;

  logic [7:0]        v [16];
  logic [15:0]       ireg;
  logic [RAM_AW-1:0] pc;
  logic [3:0]        sp;
  logic [RAM_AW-1:0] stack [c8_pkg::STACK_DEPTH];
  logic [7:0]        dt;
  logic [7:0]        st;
  logic [31:0]       seed;
  logic [15:0]       keys;
  logic              draw_pending;

  logic [15:0] op;
  logic [7:0]  va;
  logic [7:0]  vb;
  logic [RAM_AW-1:0] sweep;
  logic [3:0]  loop_i;
  logic [3:0]  row;
  logic [3:0]  bitc;
  logic [7:0]  line;
  logic        hit;
  logic [15:0] done;
  logic        pix;

  logic [RAM_AW-1:0]   ram_addr;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;
  logic [FRAME_AW-1:0] frame_addr;
  logic                frame_wdata;
  logic                frame_rdata;

  logic [3:0] ox, oy, on;
  logic [7:0] kk;
  logic [RAM_AW-1:0] nnn;
  assign ox  = op[11:8];
  assign oy  = op[7:4];
  assign on  = op[3:0];
  assign kk  = op[7:0];
  assign nnn = op[RAM_AW-1:0];

  // register file read port
  logic [3:0] vaddr;
  logic [7:0] vrd;
  always_comb begin
    unique case (cmd.vsel)
      c8_pkg::VS_X:    vaddr = ox;
      c8_pkg::VS_Y:    vaddr = oy;
      c8_pkg::VS_ZERO: vaddr = 4'd0;
      c8_pkg::VS_LOOP: vaddr = loop_i;
      default:         vaddr = ox;
    endcase
  end
  assign vrd = v[vaddr];

  // BCD digits of Vx
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_r;
  logic [14:0] bcd_m;
  logic [3:0]  bcd_t;
  logic [3:0]  bcd_o;
  logic [7:0]  bcd_digit;
  always_comb begin
    if (va >= 8'd200) begin
      bcd_h = 2'd2;
      bcd_r = va - 8'd200;
    end else if (va >= 8'd100) begin
      bcd_h = 2'd1;
      bcd_r = va - 8'd100;
    end else begin
      bcd_h = 2'd0;
      bcd_r = va;
    end
    bcd_m = 15'(bcd_r) * 15'd205;
    bcd_t = bcd_m[14:11];
    bcd_o = 4'(bcd_r - 8'(bcd_t) * 8'd10);
    unique case (loop_i[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_h};
      2'd1:    bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = {4'd0, bcd_o};
    endcase
  end

  // sprite pixel position
  logic [15:0] spr_pos;
  logic        spr_in_frame;
  logic        spr_bit;
  logic [FRAME_AW-1:0] spr_addr;
  always_comb begin
    spr_pos = 16'(va) + ((16'(vb) + 16'(row)) << $clog2(c8_pkg::SCREEN_WIDTH))
              + 16'(bitc);
    spr_in_frame = spr_pos < 16'(c8_pkg::FRAME_SIZE);
    spr_bit = line[3'd7 - bitc[2:0]];
    if (spr_in_frame) begin
      spr_addr = spr_pos[FRAME_AW-1:0];
    end else begin
      spr_addr = FRAME_AW'(spr_pos & 16'(c8_pkg::SCREEN_WIDTH - 1));
    end
  end

  // RAM port
  always_comb begin
    unique case (cmd.ram_asel)
      c8_pkg::RA_SWEEP:  ram_addr = sweep;
      c8_pkg::RA_PC:     ram_addr = pc;
      c8_pkg::RA_PC1:    ram_addr = pc + RAM_AW'(1);
      c8_pkg::RA_IDX:    ram_addr = ireg[RAM_AW-1:0] + RAM_AW'(loop_i);
      c8_pkg::RA_ROM:    ram_addr = c8_pkg::PROG_START + RAM_AW'(rom_offset);
      c8_pkg::RA_SPRITE: ram_addr = ireg[RAM_AW-1:0] + RAM_AW'(row);
      default:           ram_addr = pc;
    endcase
    unique case (cmd.ram_wsel)
      c8_pkg::RW_ZERO: ram_wdata = 8'd0;
      c8_pkg::RW_FONT: ram_wdata = c8_pkg::FONT[sweep[c8_pkg::FONT_AW-1:0]];
      c8_pkg::RW_ROM:  ram_wdata = data_byte;
      c8_pkg::RW_BCD:  ram_wdata = bcd_digit;
      c8_pkg::RW_VREG: ram_wdata = vrd;
      default:         ram_wdata = 8'd0;
    endcase
  end

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::RAM_BYTES)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (cmd.frame_asel)
      c8_pkg::FA_SWEEP:  frame_addr = sweep[FRAME_AW-1:0];
      c8_pkg::FA_PIXEL:  frame_addr = FRAME_AW'({pixel_y, pixel_x});
      c8_pkg::FA_SPRITE: frame_addr = spr_addr;
      default:           frame_addr = sweep[FRAME_AW-1:0];
    endcase
    frame_wdata = cmd.frame_toggle & ~frame_rdata;
  end

  c8_ram #(.WIDTH(1), .DEPTH(c8_pkg::FRAME_SIZE)) u_frame (
    .clk   (clk),
    .we    (cmd.frame_we),
    .addr  (frame_addr),
    .wdata (frame_wdata),
    .rdata (frame_rdata)
  );

  // random source
  logic [31:0] seed_next;
  assign seed_next = 32'(seed * c8_pkg::LCG_MUL) + c8_pkg::LCG_INC;

  // key search
  logic       key_any;
  logic [3:0] key_first;
  always_comb begin
    key_any = |keys;
    key_first = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys[k]) begin
        key_first = 4'(k);
      end
    end
  end

  // combinational instruction decode
  logic              vx_we;
  logic [7:0]        vx_val;
  logic              vf_we;
  logic              vf_val;
  logic              pc_load;
  logic [RAM_AW-1:0] pc_val;
  logic              i_load;
  logic [15:0]       i_val;
  logic              sp_push;
  logic              sp_pop;
  logic              dt_load;
  logic              st_load;
  logic              seed_step;
  logic [8:0]        sum9;
  logic [RAM_AW-1:0] pc_skip;

  assign sum9    = {1'b0, va} + {1'b0, vb};
  assign pc_skip = pc + RAM_AW'(2);

  always_comb begin
    vx_we = 1'b0;
    vx_val = va;
    vf_we = 1'b0;
    vf_val = 1'b0;
    pc_load = 1'b0;
    pc_val = pc_skip;
    i_load = 1'b0;
    i_val = ireg;
    sp_push = 1'b0;
    sp_pop = 1'b0;
    dt_load = 1'b0;
    st_load = 1'b0;
    seed_step = 1'b0;
    unique case (op[15:12])
      4'h0: begin
        if (kk == c8_pkg::OP_RET) begin
          pc_load = 1'b1;
          pc_val = stack[sp];
          sp_pop = 1'b1;
        end
      end
      4'h1: begin
        pc_load = 1'b1;
        pc_val = nnn;
      end
      4'h2: begin
        sp_push = 1'b1;
        pc_load = 1'b1;
        pc_val = nnn;
      end
      4'h3: pc_load = (va == kk);
      4'h4: pc_load = (va != kk);
      4'h5: pc_load = (va == vb);
      4'h6: begin
        vx_we = 1'b1;
        vx_val = kk;
      end
      4'h7: begin
        vx_we = 1'b1;
        vx_val = va + kk;
      end
      4'h8: begin
        unique case (on)
          4'h0: begin
            vx_we = 1'b1;
            vx_val = vb;
          end
          4'h1: begin
            vx_we = 1'b1;
            vx_val = va | vb;
          end
          4'h2: begin
            vx_we = 1'b1;
            vx_val = va & vb;
          end
          4'h3: begin
            vx_we = 1'b1;
            vx_val = va ^ vb;
          end
          4'h4: begin
            vx_we = 1'b1;
            vx_val = sum9[7:0];
            vf_we = 1'b1;
            vf_val = sum9[8];
          end
          4'h5: begin
            vx_we = 1'b1;
            vx_val = va - vb;
            vf_we = 1'b1;
            vf_val = va > vb;
          end
          4'h6: begin
            vx_we = 1'b1;
            vx_val = va >> 1;
            vf_we = 1'b1;
            vf_val = va[0];
          end
          4'h7: begin
            vx_we = 1'b1;
            vx_val = vb - va;
            vf_we = 1'b1;
            vf_val = vb > va;
          end
          4'hE: begin
            vx_we = 1'b1;
            vx_val = va << 1;
            vf_we = 1'b1;
            vf_val = va[7];
          end
          default: ;
        endcase
      end
      4'h9: pc_load = (va != vb);
      4'hA: begin
        i_load = 1'b1;
        i_val = 16'(nnn);
      end
      4'hB: begin
        pc_load = 1'b1;
        pc_val = RAM_AW'(va) + nnn;
      end
      4'hC: begin
        seed_step = 1'b1;
        vx_we = 1'b1;
        vx_val = seed_next[23:16] & kk;
      end
      4'hD: ;
      4'hE: begin
        if (kk == c8_pkg::OP_SKP) begin
          pc_load = keys[va[3:0]];
        end else if (kk == c8_pkg::OP_SKNP) begin
          pc_load = ~keys[va[3:0]];
        end
      end
      4'hF: begin
        unique case (kk)
          c8_pkg::OP_GET_DT: begin
            vx_we = 1'b1;
            vx_val = dt;
          end
          c8_pkg::OP_WAIT_KEY: begin
            if (key_any) begin
              vx_we = 1'b1;
              vx_val = 8'(key_first);
            end else begin
              pc_load = 1'b1;
              pc_val = pc - RAM_AW'(2);
            end
          end
          c8_pkg::OP_SET_DT: dt_load = 1'b1;
          c8_pkg::OP_SET_ST: st_load = 1'b1;
          c8_pkg::OP_ADD_I: begin
            i_load = 1'b1;
            i_val = ireg + 16'(va);
          end
          c8_pkg::OP_FONT: begin
            i_load = 1'b1;
            i_val = 16'(va) * 16'd5;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      ipf <= 16'd10;
      vsync <= 1'b1;
      wrap <= 1'b0;
      for (int k = 0; k < 16; k++) begin
        v[k] <= 8'd0;
      end
      for (int k = 0; k < c8_pkg::STACK_DEPTH; k++) begin
        stack[k] <= '0;
      end
      ireg <= 16'd0;
      pc <= '0;
      sp <= 4'd0;
      dt <= 8'd0;
      st <= 8'd0;
      seed <= 32'd0;
      keys <= 16'd0;
      draw_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          c8_pkg::CFG_IPF:   ipf <= cfg_data;
          c8_pkg::CFG_VSYNC: vsync <= cfg_data[0];
          c8_pkg::CFG_WRAP:  wrap <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.machine_clear) begin
        for (int k = 0; k < 16; k++) begin
          v[k] <= 8'd0;
        end
        for (int k = 0; k < c8_pkg::STACK_DEPTH; k++) begin
          stack[k] <= '0;
        end
        ireg <= 16'd0;
        sp <= 4'd0;
        dt <= 8'd0;
        st <= 8'd0;
        keys <= 16'd0;
        draw_pending <= 1'b0;
        pc <= c8_pkg::PROG_START;
      end
      if (cmd.key_write) begin
        keys[key_index] <= key_pressed;
      end
      if (cmd.run_start) begin
        draw_pending <= 1'b0;
      end
      if (cmd.pc_step) begin
        pc <= pc_skip;
      end
      if (cmd.exec) begin
        if (vx_we) begin
          v[ox] <= vx_val;
        end
        if (vf_we) begin
          v[15] <= {7'd0, vf_val};
        end
        if (pc_load) begin
          pc <= pc_val;
        end
        if (i_load) begin
          ireg <= i_val;
        end
        if (sp_push) begin
          sp <= sp + 4'd1;
          stack[sp + 4'd1] <= pc;
        end
        if (sp_pop) begin
          sp <= sp - 4'd1;
        end
        if (dt_load) begin
          dt <= va;
        end
        if (st_load) begin
          st <= va;
        end
        if (seed_step) begin
          seed <= seed_next;
        end
      end
      if (cmd.v_load) begin
        v[loop_i] <= ram_rdata;
      end
      if (cmd.vf_hit) begin
        v[15] <= {7'd0, hit};
      end
      if (cmd.draw_set) begin
        draw_pending <= 1'b1;
      end
      if (cmd.timers_dec) begin
        if (dt != 8'd0) begin
          dt <= dt - 8'd1;
        end
        if (st != 8'd0) begin
          st <= st - 8'd1;
        end
      end
    end
  end

  // sequencing counters and operand latches
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      loop_i <= 4'd0;
      row <= 4'd0;
      bitc <= 4'd0;
      done <= 16'd0;
      hit <= 1'b0;
      pix <= 1'b0;
    end else begin
      if (cmd.accept) begin
        done <= 16'd0;
        pix <= 1'b0;
      end
      if (cmd.pix_latch) begin
        pix <= frame_rdata;
      end
      if (cmd.sweep_clr) begin
        sweep <= '0;
      end else if (cmd.sweep_inc) begin
        sweep <= sweep + RAM_AW'(1);
      end
      if (cmd.loop_clr) begin
        loop_i <= 4'd0;
      end else if (cmd.loop_inc) begin
        loop_i <= loop_i + 4'd1;
      end
      if (cmd.spr_start) begin
        row <= 4'd0;
        hit <= 1'b0;
      end
      if (cmd.row_inc) begin
        row <= row + 4'd1;
      end
      if (cmd.line_latch) begin
        bitc <= 4'd0;
      end else if (cmd.bit_inc) begin
        bitc <= bitc + 4'd1;
      end
      if (cmd.hit_update) begin
        hit <= hit | frame_rdata;
      end
      if (cmd.count_inc) begin
        done <= done + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_hi_latch) begin
      op[15:8] <= ram_rdata;
    end
    if (cmd.op_lo_latch) begin
      op[7:0] <= ram_rdata;
    end
    if (cmd.va_latch) begin
      va <= vrd;
    end
    if (cmd.vb_latch) begin
      vb <= vrd;
    end
    if (cmd.line_latch) begin
      line <= ram_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      draw_flag <= draw_pending;
      sound_on <= (st != 8'd0);
      pixel_value <= pix;
      instructions_done <= done;
    end
  end

  always_comb begin
    stat.op = op;
    stat.sweep_last_ram = (sweep == RAM_AW'(c8_pkg::RAM_BYTES - 1));
    stat.sweep_last_frame = (sweep == RAM_AW'(c8_pkg::FRAME_SIZE - 1));
    stat.sweep_in_frame = (sweep < RAM_AW'(c8_pkg::FRAME_SIZE));
    stat.sweep_font = (sweep < RAM_AW'(c8_pkg::FONT_BYTES));
    stat.loop_last = (loop_i == ox);
    stat.bcd_last = (loop_i == c8_pkg::BCD_LAST);
    stat.row_end = (row == on);
    stat.bit_end = (bitc == 4'd8);
    stat.pix_hit = spr_bit && (spr_in_frame || wrap);
    stat.ipf_zero = (ipf == 16'd0);
    stat.count_last = ((done + 16'd1) == ipf);
    stat.stop_vsync = draw_pending && vsync;
    stat.out_busy = out_valid && !out_ready;
  end

endmodule

// ----- rtl/c8_control.sv -----
`timescale 1ns / 1ps
// Controller state machine: item dispatch, instruction sequencing, memory sweeps.
// Depends on c8_pkg; drives c8_datapath through cmd_t, reads stat_t.
module c8_control (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    kind,
  input  c8_pkg::stat_t stat,
  output c8_pkg::cmd_t  cmd
);

  c8_pkg::state_t state;
  c8_pkg::state_t state_next;
  logic           soft_mode;
  logic           soft_mode_next;
  logic [3:0]     grp;
  logic [7:0]     kk;

  assign grp = stat.op[15:12];
  assign kk  = stat.op[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c8_pkg::ST_INIT;
      soft_mode <= 1'b0;
    end else begin
      state <= state_next;
      soft_mode <= soft_mode_next;
    end
  end

  always_comb begin
    state_next = state;
    soft_mode_next = soft_mode;
    unique case (state)
      c8_pkg::ST_INIT: begin
        if (stat.sweep_last_ram) state_next = c8_pkg::ST_IDLE;
      end
      c8_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            c8_pkg::KIND_FULL_RESET: begin
              state_next = c8_pkg::ST_SWEEP;
              soft_mode_next = 1'b0;
            end
            c8_pkg::KIND_SOFT_RESET: begin
              state_next = c8_pkg::ST_SWEEP;
              soft_mode_next = 1'b1;
            end
            c8_pkg::KIND_PIXEL_READ: state_next = c8_pkg::ST_PIX_DATA;
            c8_pkg::KIND_FRAME_RUN:  state_next = c8_pkg::ST_RUN_START;
            default:                 state_next = c8_pkg::ST_DONE;
          endcase
        end
      end
      c8_pkg::ST_SWEEP: begin
        if (stat.sweep_last_ram) state_next = c8_pkg::ST_DONE;
      end
      c8_pkg::ST_PIX_DATA: state_next = c8_pkg::ST_DONE;
      c8_pkg::ST_RUN_START: begin
        state_next = stat.ipf_zero ? c8_pkg::ST_TIMERS : c8_pkg::ST_FETCH0;
      end
      c8_pkg::ST_FETCH0: state_next = c8_pkg::ST_FETCH1;
      c8_pkg::ST_FETCH1: state_next = c8_pkg::ST_FETCH2;
      c8_pkg::ST_FETCH2: state_next = c8_pkg::ST_READ_X;
      c8_pkg::ST_READ_X: state_next = c8_pkg::ST_READ_Y;
      c8_pkg::ST_READ_Y: state_next = c8_pkg::ST_EXEC;
      c8_pkg::ST_EXEC: begin
        if (grp == c8_pkg::GRP_SYS && kk == c8_pkg::OP_CLS) begin
          state_next = c8_pkg::ST_CLS;
        end else if (grp == c8_pkg::GRP_DRAW) begin
          state_next = c8_pkg::ST_SPR_ROW;
        end else if (grp == c8_pkg::GRP_MISC && kk == c8_pkg::OP_BCD) begin
          state_next = c8_pkg::ST_BCD;
        end else if (grp == c8_pkg::GRP_MISC && kk == c8_pkg::OP_STORE) begin
          state_next = c8_pkg::ST_STORE;
        end else if (grp == c8_pkg::GRP_MISC && kk == c8_pkg::OP_LOAD) begin
          state_next = c8_pkg::ST_LOAD_ADDR;
        end else begin
          state_next = c8_pkg::ST_POST;
        end
      end
      c8_pkg::ST_CLS: begin
        if (stat.sweep_last_frame) state_next = c8_pkg::ST_POST;
      end
      c8_pkg::ST_SPR_ROW: begin
        state_next = stat.row_end ? c8_pkg::ST_POST : c8_pkg::ST_SPR_LINE;
      end
      c8_pkg::ST_SPR_LINE: state_next = c8_pkg::ST_SPR_BIT;
      c8_pkg::ST_SPR_BIT: begin
        if (stat.bit_end) begin
          state_next = c8_pkg::ST_SPR_ROW;
        end else if (stat.pix_hit) begin
          state_next = c8_pkg::ST_SPR_XOR;
        end
      end
      c8_pkg::ST_SPR_XOR: state_next = c8_pkg::ST_SPR_BIT;
      c8_pkg::ST_BCD: begin
        if (stat.bcd_last) state_next = c8_pkg::ST_POST;
      end
      c8_pkg::ST_STORE: begin
        if (stat.loop_last) state_next = c8_pkg::ST_POST;
      end
      c8_pkg::ST_LOAD_ADDR: state_next = c8_pkg::ST_LOAD_DATA;
      c8_pkg::ST_LOAD_DATA: begin
        state_next = stat.loop_last ? c8_pkg::ST_POST : c8_pkg::ST_LOAD_ADDR;
      end
      c8_pkg::ST_POST: begin
        if (stat.stop_vsync || stat.count_last) begin
          state_next = c8_pkg::ST_TIMERS;
        end else begin
          state_next = c8_pkg::ST_FETCH0;
        end
      end
      c8_pkg::ST_TIMERS: state_next = c8_pkg::ST_DONE;
      c8_pkg::ST_DONE: begin
        if (!stat.out_busy) state_next = c8_pkg::ST_IDLE;
      end
      default: state_next = c8_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      c8_pkg::ST_INIT: begin
        cmd.ram_asel = c8_pkg::RA_SWEEP;
        cmd.ram_we = 1'b1;
        cmd.ram_wsel = c8_pkg::RW_ZERO;
        cmd.frame_asel = c8_pkg::FA_SWEEP;
        cmd.frame_we = stat.sweep_in_frame;
        cmd.sweep_inc = 1'b1;
      end
      c8_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (kind)
            c8_pkg::KIND_FULL_RESET, c8_pkg::KIND_SOFT_RESET: begin
              cmd.machine_clear = 1'b1;
              cmd.sweep_clr = 1'b1;
            end
            c8_pkg::KIND_ROM_BYTE: begin
              cmd.ram_asel = c8_pkg::RA_ROM;
              cmd.ram_wsel = c8_pkg::RW_ROM;
              cmd.ram_we = 1'b1;
            end
            c8_pkg::KIND_KEY:        cmd.key_write = 1'b1;
            c8_pkg::KIND_PIXEL_READ: cmd.frame_asel = c8_pkg::FA_PIXEL;
            c8_pkg::KIND_FRAME_RUN:  cmd.run_start = 1'b1;
            default: ;
          endcase
        end
      end
      c8_pkg::ST_SWEEP: begin
        cmd.ram_asel = c8_pkg::RA_SWEEP;
        cmd.ram_we = !(soft_mode && stat.sweep_font);
        cmd.ram_wsel = stat.sweep_font ? c8_pkg::RW_FONT : c8_pkg::RW_ZERO;
        cmd.frame_asel = c8_pkg::FA_SWEEP;
        cmd.frame_we = stat.sweep_in_frame;
        cmd.sweep_inc = 1'b1;
      end
      c8_pkg::ST_PIX_DATA: cmd.pix_latch = 1'b1;
      c8_pkg::ST_RUN_START: ;
      c8_pkg::ST_FETCH0: cmd.ram_asel = c8_pkg::RA_PC;
      c8_pkg::ST_FETCH1: begin
        cmd.ram_asel = c8_pkg::RA_PC1;
        cmd.op_hi_latch = 1'b1;
      end
      c8_pkg::ST_FETCH2: cmd.op_lo_latch = 1'b1;
      c8_pkg::ST_READ_X: begin
        cmd.vsel = (grp == c8_pkg::GRP_JMP_V0) ? c8_pkg::VS_ZERO : c8_pkg::VS_X;
        cmd.va_latch = 1'b1;
        cmd.pc_step = 1'b1;
      end
      c8_pkg::ST_READ_Y: begin
        cmd.vsel = c8_pkg::VS_Y;
        cmd.vb_latch = 1'b1;
      end
      c8_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.loop_clr = 1'b1;
        cmd.spr_start = 1'b1;
        cmd.sweep_clr = 1'b1;
      end
      c8_pkg::ST_CLS: begin
        cmd.frame_asel = c8_pkg::FA_SWEEP;
        cmd.frame_we = 1'b1;
        cmd.sweep_inc = 1'b1;
        cmd.draw_set = stat.sweep_last_frame;
      end
      c8_pkg::ST_SPR_ROW: begin
        cmd.ram_asel = c8_pkg::RA_SPRITE;
        cmd.vf_hit = stat.row_end;
        cmd.draw_set = stat.row_end;
      end
      c8_pkg::ST_SPR_LINE: cmd.line_latch = 1'b1;
      c8_pkg::ST_SPR_BIT: begin
        cmd.frame_asel = c8_pkg::FA_SPRITE;
        cmd.row_inc = stat.bit_end;
        cmd.bit_inc = !stat.bit_end && !stat.pix_hit;
      end
      c8_pkg::ST_SPR_XOR: begin
        cmd.frame_asel = c8_pkg::FA_SPRITE;
        cmd.frame_we = 1'b1;
        cmd.frame_toggle = 1'b1;
        cmd.hit_update = 1'b1;
        cmd.bit_inc = 1'b1;
      end
      c8_pkg::ST_BCD: begin
        cmd.ram_asel = c8_pkg::RA_IDX;
        cmd.ram_we = 1'b1;
        cmd.ram_wsel = c8_pkg::RW_BCD;
        cmd.loop_inc = !stat.bcd_last;
      end
      c8_pkg::ST_STORE: begin
        cmd.vsel = c8_pkg::VS_LOOP;
        cmd.ram_asel = c8_pkg::RA_IDX;
        cmd.ram_we = 1'b1;
        cmd.ram_wsel = c8_pkg::RW_VREG;
        cmd.loop_inc = !stat.loop_last;
      end
      c8_pkg::ST_LOAD_ADDR: cmd.ram_asel = c8_pkg::RA_IDX;
      c8_pkg::ST_LOAD_DATA: begin
        cmd.v_load = 1'b1;
        cmd.loop_inc = !stat.loop_last;
      end
      c8_pkg::ST_POST:   cmd.count_inc = 1'b1;
      c8_pkg::ST_TIMERS: cmd.timers_dec = 1'b1;
      c8_pkg::ST_DONE:   cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- rtl/chip8_interpreter_core.sv -----
`timescale 1ns / 1ps
// Top level of the CHIP-8 interpreter core: controller plus datapath.
// Depends on c8_pkg, c8_control and c8_datapath.
//
// One transaction in, one result out. After reset the core runs a clearing pass
// over program RAM and frame memory, one RAM address per cycle, before taking a
// transaction. The work per transaction is bounded by the single port of the
// program RAM and of the frame memory: a full or soft reset sweeps every RAM address
// again; a frame run fetches and executes instructions one at a time, a screen clear
// walks every frame address, a register store or BCD writes one byte per step, a
// register load reads and then writes each of its bytes, and a sprite is drawn row
// by row and bit by bit, with an extra step per lit pixel that lands in the frame
// or, with wrap enabled, falls outside it. The result register lets a new transaction
// start while the previous result waits; the next result then stalls until the waiting one is taken.
module chip8_interpreter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [11:0] rom_offset,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  key_index,
  input  logic        key_pressed,
  input  logic [5:0]  pixel_x,
  input  logic [4:0]  pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        draw_flag,
  output logic        sound_on,
  output logic        pixel_value,
  output logic [15:0] instructions_done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  c8_pkg::cmd_t  cmd;
  c8_pkg::stat_t stat;

  c8_control u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  c8_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .rom_offset        (rom_offset),
    .data_byte         (data_byte),
    .key_index         (key_index),
    .key_pressed       (key_pressed),
    .pixel_x           (pixel_x),
    .pixel_y           (pixel_y),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .draw_flag         (draw_flag),
    .sound_on          (sound_on),
    .pixel_value       (pixel_value),
    .instructions_done (instructions_done)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("core ready right after accepting a transaction");

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without a result load");

  a_toggle_after_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.frame_we && cmd.frame_toggle) |-> $past(stat.pix_hit))
    else $error("frame pixel toggled without a lit sprite bit");

endmodule
